>>> hdl/euler_yxz_view_matrix_macros.svh
// Assertion macros shared by the view matrix RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef EULER_YXZ_VIEW_MATRIX_MACROS_SVH
`define EULER_YXZ_VIEW_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define EVM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EVM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/evm_pkg.sv
// Package for the Euler Y-X-Z view matrix: payload types, CORDIC constants and
// rounding helpers. Depends on nothing.
package evm_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CS            = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CW            = 36;

  localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;

  localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
    36'sd67021686, 36'sd33543515, 36'sd16775850, 36'sd8388437,
    36'sd4194282, 36'sd2097149, 36'sd1048575, 36'sd524287,
    36'sd262143, 36'sd131071, 36'sd65535, 36'sd32767,
    36'sd16383, 36'sd8191, 36'sd4095, 36'sd2047,
    36'sd1023, 36'sd511, 36'sd255, 36'sd127
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } evm_in_t;

  typedef struct packed {
    logic signed [15:0] u_x;
    logic signed [15:0] u_y;
    logic signed [15:0] u_z;
    logic signed [15:0] v_x;
    logic signed [15:0] v_y;
    logic signed [15:0] v_z;
    logic signed [15:0] w_x;
    logic signed [15:0] w_y;
    logic signed [15:0] w_z;
    logic signed [31:0] trans_u;
    logic signed [31:0] trans_v;
    logic signed [31:0] trans_w;
  } evm_out_t;

  // CORDIC iteration state for one angle.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } evm_cordic_t;

  // Round a 64-bit value right by k (half up) and clamp to [-16384, 16384].
  function automatic logic signed [15:0] q14_round(input logic signed [63:0] v,
                                                   input int k);
    logic signed [63:0] r;
    begin
      r = (v + (64'sd1 <<< (k - 1))) >>> k;
      if (r > 64'sd16384) q14_round = 16'sd16384;
      else if (r < -64'sd16384) q14_round = -16'sd16384;
      else q14_round = r[15:0];
    end
  endfunction

endpackage

>>> hdl/evm_cordic.sv
// Unrolled, pipelined rotation-mode CORDIC giving Q1.14 sine and cosine.
// Depends on evm_pkg; one register stage per iteration, advancing on en.
module evm_cordic
  import evm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);

  evm_cordic_t st_r [CS+1];
  evm_cordic_t st_nxt [CS+1];
  logic signed [15:0] s_r, c_r;
  logic signed [15:0] s_nxt, c_nxt;
  logic signed [CW-1:0] z0;

  always_comb begin
    z0 = CW'(angle) <<< 17;
    st_nxt[0].x = GAIN_Q30;
    st_nxt[0].y = '0;
    if (z0 > HALF_PI_Q30) begin
      st_nxt[0].z = z0 - PI_Q30;
      st_nxt[0].flip = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      st_nxt[0].z = z0 + PI_Q30;
      st_nxt[0].flip = 1'b1;
    end else begin
      st_nxt[0].z = z0;
      st_nxt[0].flip = 1'b0;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_it
    always_comb begin
      st_nxt[i+1].flip = st_r[i].flip;
      if (!st_r[i].z[CW-1]) begin
        st_nxt[i+1].x = st_r[i].x - (st_r[i].y >>> i);
        st_nxt[i+1].y = st_r[i].y + (st_r[i].x >>> i);
        st_nxt[i+1].z = st_r[i].z - ATAN_Q30[i];
      end else begin
        st_nxt[i+1].x = st_r[i].x + (st_r[i].y >>> i);
        st_nxt[i+1].y = st_r[i].y - (st_r[i].x >>> i);
        st_nxt[i+1].z = st_r[i].z + ATAN_Q30[i];
      end
    end
  end

  always_comb begin
    c_nxt = q14_round(64'(st_r[CS].x), 16);
    s_nxt = q14_round(64'(st_r[CS].y), 16);
    if (st_r[CS].flip) begin
      c_nxt = -c_nxt;
      s_nxt = -s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= CS; i++) st_r[i] <= (i == 0) ? st_nxt[0] : st_nxt[i];
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end

  assign sin_q14 = s_r;
  assign cos_q14 = c_r;

endmodule

>>> hdl/euler_yxz_view_matrix.sv
// Euler Y-X-Z view matrix: camera position and three angles in, rotation
// basis and translation out. Depends on evm_pkg, evm_cordic and the macros.
//
// The block takes one beat per cycle while the pipeline advances and keeps
// no state between beats. Each beat passes through CORDIC_STAGES+2 CORDIC
// registers, a product stage, a basis stage, a rounding stage, a dot-product
// stage and a saturation stage. The pipeline advances whenever the output
// register is empty or its beat is being taken, so a stalled consumer
// freezes every stage and nothing is lost or repeated.
`include "euler_yxz_view_matrix_macros.svh"
module euler_yxz_view_matrix
  import evm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  evm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output evm_out_t out_data
);

  localparam int CL  = CS + 2;       // CORDIC latency
  localparam int LAT = CL + 5;

  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Position travels alongside the CORDIC.
  logic signed [31:0] px_r [CL+3];
  logic signed [31:0] py_r [CL+3];
  logic signed [31:0] pz_r [CL+3];
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0] <= in_data.pos_x;
      py_r[0] <= in_data.pos_y;
      pz_r[0] <= in_data.pos_z;
      for (int i = 1; i < CL + 3; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  logic signed [15:0] s1, c1, s2, c2, s3, c3;
  evm_cordic u_cy (.clk, .en(adv), .angle(in_data.angle_y), .sin_q14(s1), .cos_q14(c1));
  evm_cordic u_cx (.clk, .en(adv), .angle(in_data.angle_x), .sin_q14(s2), .cos_q14(c2));
  evm_cordic u_cz (.clk, .en(adv), .angle(in_data.angle_z), .sin_q14(s3), .cos_q14(c3));

  // Stage A: pairwise products (Q28).
  logic signed [31:0] c1c3_r, s1s2_r, c1s2_r, c3s1_r, c1s3_r, s1s3_r;
  logic signed [31:0] c2s3_r, c2c3_r, c2s1_r, c1c2_r;
  logic signed [15:0] s3_r, ns2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1c3_r <= c1 * c3; s1s2_r <= s1 * s2; c1s2_r <= c1 * s2;
      c3s1_r <= c3 * s1; c1s3_r <= c1 * s3; s1s3_r <= s1 * s3;
      c2s3_r <= c2 * s3; c2c3_r <= c2 * c3; c2s1_r <= c2 * s1;
      c1c2_r <= c1 * c2;
      s3_r   <= s3;      ns2_r  <= -s2;
    end
  end

  // Stage B: Q42 sums, one product per summed entry; the rest pass through.
  logic signed [47:0] m0_r, m2_r, m3_r, m5_r;
  logic signed [31:0] m1_r, m4_r, m6_r, m8_r;
  logic signed [15:0] m7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r <= (48'(c1c3_r) <<< 14) + s1s2_r * s3_r;
      m2_r <= c1s2_r * s3_r - (48'(c3s1_r) <<< 14);
      m3_r <= c3s1_r * ns2_r * -48'sd1 - (48'(c1s3_r) <<< 14);
      m5_r <= c1c3_r * -ns2_r + (48'(s1s3_r) <<< 14);
      m1_r <= c2s3_r; m4_r <= c2c3_r; m6_r <= c2s1_r; m8_r <= c1c2_r;
      m7_r <= ns2_r;
    end
  end

  // Stage C: round basis to Q1.14.
  logic signed [15:0] b_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      b_r[0] <= q14_round(64'(m0_r), 28);
      b_r[1] <= q14_round(64'(m1_r), 14);
      b_r[2] <= q14_round(64'(m2_r), 28);
      b_r[3] <= q14_round(64'(m3_r), 28);
      b_r[4] <= q14_round(64'(m4_r), 14);
      b_r[5] <= q14_round(64'(m5_r), 28);
      b_r[6] <= q14_round(64'(m6_r), 14);
      b_r[7] <= m7_r;
      b_r[8] <= q14_round(64'(m8_r), 14);
    end
  end

  // Stage D: dot products.
  logic signed [15:0] bd_r [9];
  logic signed [49:0] dot_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dot_r[k] <= 50'(b_r[3*k] * px_r[CL+2]) + 50'(b_r[3*k+1] * py_r[CL+2])
                  + 50'(b_r[3*k+2] * pz_r[CL+2]);
      end
      bd_r <= b_r;
    end
  end

  // Stage E: negate, round, saturate, and hold for the consumer.
  evm_out_t out_r;
  logic signed [31:0] t_nxt [3];
  always_comb begin
    logic signed [50:0] r;
    for (int k = 0; k < 3; k++) begin
      r = (-51'(dot_r[k]) + 51'sd8192) >>> 14;
      if (r > 51'sd2147483647) t_nxt[k] = 32'sh7fffffff;
      else if (r < -51'sd2147483648) t_nxt[k] = 32'sh80000000;
      else t_nxt[k] = r[31:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= '{bd_r[0], bd_r[1], bd_r[2], bd_r[3], bd_r[4], bd_r[5],
                 bd_r[6], bd_r[7], bd_r[8], t_nxt[0], t_nxt[1], t_nxt[2]};
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  `EVM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `EVM_ASSERT_IMPL(a_rdy, clk, rst_n, !out_valid, in_ready)
  `EVM_ASSERT_IMPL(a_wy, clk, rst_n, out_valid, out_data.w_y >= -16'sd16384 && out_data.w_y <= 16'sd16384)

endmodule

>>> verif/tb.sv
// Self-checking bench for the Euler Y-X-Z view matrix: drives position and
// angle beats, predicts the basis and translation, and compares each result.
// Depends on evm_pkg and the euler_yxz_view_matrix RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import evm_pkg::*;

  localparam int NUM_RANDOM = 800;
  localparam int LATENCY    = CORDIC_STAGES + 7;
  localparam int CYCLE_MAX  = 200000;

  // CORDIC constants (Q30) and the translation saturation bounds.
  localparam longint GAIN    = 64'd652032874;
  localparam longint HALF_PI = 64'd1686629713;
  localparam longint PI_VAL  = 64'd3373259426;
  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  evm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  evm_out_t out_data;

  euler_yxz_view_matrix u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  evm_out_t pending_views[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       calm = 1'b0;  // when set, neither side idles

  // Arctangent table of the CORDIC, Q30.
  longint arctan_q30[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rounds half up by an arithmetic (floor) shift.
  function automatic longint round_down_by(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  // Sine and cosine of a Q3.13 angle, both Q1.14.
  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 131072;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    // Beyond a quarter turn the angle is folded by pi and both signs flip.
    if (z > HALF_PI) begin
      z -= PI_VAL;
      flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI_VAL;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_q30[i];
      end
      x = nx;
    end
    c = clip(round_down_by(x, 16), -16384, 16384);
    s = clip(round_down_by(y, 16), -16384, 16384);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint basis2(longint p);
    return clip(round_down_by(p, 14), -16384, 16384);
  endfunction

  function automatic longint basis3(longint p);
    return clip(round_down_by(p, 28), -16384, 16384);
  endfunction

  function automatic logic signed [31:0] neg_dot(longint a, longint b, longint c,
                                                  evm_in_t p);
    longint sum;
    sum = a * longint'(p.pos_x) + b * longint'(p.pos_y) + c * longint'(p.pos_z);
    return 32'(clip(round_down_by(-sum, 14), SAT_LO, SAT_HI));
  endfunction

  function automatic evm_out_t view_of(evm_in_t b);
    longint s1, c1, s2, c2, s3, c3;
    evm_out_t r;
    sin_cos(b.angle_y, s1, c1);
    sin_cos(b.angle_x, s2, c2);
    sin_cos(b.angle_z, s3, c3);
    r.u_x = 16'(basis3(c1 * c3 * 16384 + s1 * s2 * s3));
    r.u_y = 16'(basis2(c2 * s3));
    r.u_z = 16'(basis3(c1 * s2 * s3 - c3 * s1 * 16384));
    r.v_x = 16'(basis3(c3 * s1 * s2 - c1 * s3 * 16384));
    r.v_y = 16'(basis2(c2 * c3));
    r.v_z = 16'(basis3(c1 * c3 * s2 + s1 * s3 * 16384));
    r.w_x = 16'(basis2(c2 * s1));
    r.w_y = 16'(-s2);
    r.w_z = 16'(basis2(c1 * c2));
    r.trans_u = neg_dot(r.u_x, r.u_y, r.u_z, b);
    r.trans_v = neg_dot(r.v_x, r.v_y, r.v_z, b);
    r.trans_w = neg_dot(r.w_x, r.w_y, r.w_z, b);
    return r;
  endfunction

  // Directed rows; has_view marks rows whose result is typed in by hand.
  typedef struct {
    evm_in_t  beat;
    bit       has_view;
    evm_out_t view;
  } row_t;

  localparam logic signed [15:0] A_MAX = 16'sh7fff;
  localparam logic signed [15:0] A_MIN = -16'sh8000;
  localparam logic signed [15:0] Q_TURN = 16'sd12868;  // about pi/2 in Q3.13
  localparam logic signed [31:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] P_MIN = -32'sh80000000;

  row_t rows[$];

  task automatic add_row(logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] pz, logic signed [15:0] ax,
                         logic signed [15:0] ay, logic signed [15:0] az);
    row_t r;
    r.beat = '{px, py, pz, ax, ay, az};
    r.has_view = 1'b0;
    r.view = '0;
    rows.push_back(r);
  endtask

  task automatic build_rows();
    row_t r;
    // At zero angles the CORDIC leaves a sine of one LSB and a full-scale
    // cosine, so the basis is the identity with a few off-diagonal LSBs.
    r.beat = '{32'sh10000, -32'sh20000, 32'sh30000, 16'sd0, 16'sd0, 16'sd0};
    r.has_view = 1'b1;
    r.view = '{16'sd16384, 16'sd1, -16'sd1, -16'sd1, 16'sd16384, 16'sd1,
               16'sd1, -16'sd1, 16'sd16384, -32'sd65516, 32'sd131064, -32'sd196620};
    rows.push_back(r);
    // Same basis with extreme position: trans_w saturates on the positive side.
    r.beat = '{P_MIN, P_MAX, P_MIN, 16'sd0, 16'sd0, 16'sd0};
    r.view = '{16'sd16384, 16'sd1, -16'sd1, -16'sd1, 16'sd16384, 16'sd1,
               16'sd1, -16'sd1, 16'sd16384, 32'sd2147221504, -32'sh7fffffff,
               32'(SAT_HI)};
    rows.push_back(r);
    add_row(P_MAX, P_MAX, P_MAX, A_MAX, A_MAX, A_MAX);
    add_row(P_MIN, P_MIN, P_MIN, A_MIN, A_MIN, A_MIN);
    add_row(P_MAX, P_MIN, P_MAX, A_MAX, A_MIN, 16'sd0);
    add_row(32'sd0, 32'sd0, 32'sd0, Q_TURN, -Q_TURN, Q_TURN + 16'sd1);
    add_row(32'sh10000, 32'sh10000, 32'sh10000, Q_TURN + 16'sd1, Q_TURN, -Q_TURN - 16'sd1);
    add_row(32'sh7fff0000, -32'sh12345, 32'sh4000, 16'sd25736, -16'sd25736, 16'sd6434);
    add_row(-32'sd1, 32'sd1, -32'sd1, 16'sd1, -16'sd1, 16'sd1);
    add_row(P_MAX, P_MAX, P_MAX, 16'sd6434, 16'sd6434, 16'sd6434);
    add_row(P_MIN, P_MAX, P_MIN, -16'sd6434, 16'sd19302, -16'sd19302);
    add_row(32'sh5555aaaa, 32'shaaaa5555, 32'sh0f0f0f0f, 16'sh5555, 16'shaaaa, 16'sh0f0f);
  endtask

  function automatic evm_in_t random_beat();
    evm_in_t b;
    b = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
    // Mostly modest positions so translations stay unsaturated and meaningful.
    if ($urandom_range(0, 3) != 0) begin
      b.pos_x = $signed(b.pos_x) >>> $urandom_range(0, 16);
      b.pos_y = $signed(b.pos_y) >>> $urandom_range(0, 16);
      b.pos_z = $signed(b.pos_z) >>> $urandom_range(0, 16);
    end
    return b;
  endfunction

  // Presents one beat and holds it until the block takes it. Valid stays
  // high into the next beat unless the sender idles.
  task automatic send_beat(evm_in_t b);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_views.push_back(view_of(b));
    @(negedge clk);
  endtask

  // Result side: random stalls, then check each accepted beat in order.
  always @(negedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    evm_out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_views.pop_front();
        if (out_data.u_x !== want.u_x) begin
          $error("u_x exp %0d got %0d", want.u_x, out_data.u_x); fail_count++; end
        if (out_data.u_y !== want.u_y) begin
          $error("u_y exp %0d got %0d", want.u_y, out_data.u_y); fail_count++; end
        if (out_data.u_z !== want.u_z) begin
          $error("u_z exp %0d got %0d", want.u_z, out_data.u_z); fail_count++; end
        if (out_data.v_x !== want.v_x) begin
          $error("v_x exp %0d got %0d", want.v_x, out_data.v_x); fail_count++; end
        if (out_data.v_y !== want.v_y) begin
          $error("v_y exp %0d got %0d", want.v_y, out_data.v_y); fail_count++; end
        if (out_data.v_z !== want.v_z) begin
          $error("v_z exp %0d got %0d", want.v_z, out_data.v_z); fail_count++; end
        if (out_data.w_x !== want.w_x) begin
          $error("w_x exp %0d got %0d", want.w_x, out_data.w_x); fail_count++; end
        if (out_data.w_y !== want.w_y) begin
          $error("w_y exp %0d got %0d", want.w_y, out_data.w_y); fail_count++; end
        if (out_data.w_z !== want.w_z) begin
          $error("w_z exp %0d got %0d", want.w_z, out_data.w_z); fail_count++; end
        if (out_data.trans_u !== want.trans_u) begin
          $error("trans_u exp %0d got %0d", want.trans_u, out_data.trans_u);
          fail_count++;
        end
        if (out_data.trans_v !== want.trans_v) begin
          $error("trans_v exp %0d got %0d", want.trans_v, out_data.trans_v);
          fail_count++;
        end
        if (out_data.trans_w !== want.trans_w) begin
          $error("trans_w exp %0d got %0d", want.trans_w, out_data.trans_w);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    evm_out_t typed;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    build_rows();
    // Directed table; typed-in rows must also agree with the predictor.
    foreach (rows[i]) begin
      if (rows[i].has_view) begin
        typed = view_of(rows[i].beat);
        if (typed !== rows[i].view) begin
          $error("directed row %0d: predictor disagrees with table", i);
          fail_count++;
        end
      end
      send_beat(rows[i].beat);
    end
    // Random beats: a stretch without idling, and one pause to drain.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 200 && n < 350);
      if (n == 400) begin
        in_valid <= 1'b0;
        while (pending_views.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      send_beat(random_beat());
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
